FILE: rtl/ikt_pkg.sv
`timescale 1ns / 1ps
package ikt_pkg;

    // fixed point default
    localparam int FRAC_BITS_DEF = 16;

    // field widths
    localparam int W_X      = 20;
    localparam int W_LEN    = 17;
    localparam int W_HOFF   = 18;
    localparam int W_PITCH  = 19;
    localparam int W_HIP    = 20;
    localparam int W_JNT    = 19;

    // internal datapath widths
    localparam int W_DX     = 21;
    localparam int W_DZ     = 22;
    localparam int W_NUM1   = 46;
    localparam int W_DEN1   = 35;
    localparam int W_AB     = 20;
    localparam int W_NUM3   = 44;
    localparam int W_DEN3   = 40;

    // config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam logic [CFG_IDX_W-1:0] CFG_FOOT_TO_ANKLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANKLE_TO_KNEE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KNEE_TO_HIP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIP_OFFSET_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIP_OFFSET_Z  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_OFFSET  = 3'd5;

    localparam logic [W_LEN-1:0]          RST_FOOT_TO_ANKLE = 17'd7668;
    localparam logic [W_LEN-1:0]          RST_ANKLE_TO_KNEE = 17'd25887;
    localparam logic [W_LEN-1:0]          RST_KNEE_TO_HIP   = 17'd29819;
    localparam logic signed [W_HOFF-1:0]  RST_HIP_OFFSET_X  = 18'sd0;
    localparam logic signed [W_HOFF-1:0]  RST_HIP_OFFSET_Z  = 18'sd516;
    localparam logic signed [W_PITCH-1:0] RST_PITCH_OFFSET  = -19'sd3813;

    // CORDIC, Q30 angles
    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_W     = 34;
    localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    function automatic logic signed [CORDIC_W-1:0] atan_q30(input int i);
        case (i)
            0:  return 34'sd843314856;
            1:  return 34'sd497837829;
            2:  return 34'sd263043836;
            3:  return 34'sd133525158;
            4:  return 34'sd67021686;
            5:  return 34'sd33543515;
            6:  return 34'sd16775850;
            7:  return 34'sd8388437;
            8:  return 34'sd4194282;
            9:  return 34'sd2097149;
            10: return 34'sd1048575;
            11: return 34'sd524287;
            12: return 34'sd262143;
            13: return 34'sd131071;
            14: return 34'sd65535;
            15: return 34'sd32767;
            16: return 34'sd16383;
            17: return 34'sd8191;
            18: return 34'sd4095;
            19: return 34'sd2047;
            20: return 34'sd1023;
            21: return 34'sd511;
            22: return 34'sd255;
            23: return 34'sd127;
            24: return 34'sd63;
            25: return 34'sd31;
            26: return 34'sd15;
            27: return 34'sd7;
            default: return '0;
        endcase
    endfunction

endpackage

FILE: rtl/ikt_if.sv
`timescale 1ns / 1ps

// foot target channel
interface ikt_in_if import ikt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic signed [W_X-1:0] x_target;
    logic signed [W_X-1:0] z_target;
    modport source (output valid, x_target, z_target, input ready);
    modport sink   (input valid, x_target, z_target, output ready);
endinterface

// joint angle channel
interface ikt_out_if import ikt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [W_HIP-1:0] hip_angle;
    logic signed [W_JNT-1:0] knee_angle;
    logic signed [W_JNT-1:0] ankle_angle;
    logic                    unreachable;
    modport source (output valid, hip_angle, knee_angle, ankle_angle, unreachable,
                    input ready);
    modport sink   (input valid, hip_angle, knee_angle, ankle_angle, unreachable,
                    output ready);
endinterface

// register write channel
interface ikt_cfg_if import ikt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/ikt_cosdiv.sv
`timescale 1ns / 1ps
// Clamped cosine quotient: c = sign(num) * trunc(|num| * 2^F / den), one quotient
// bit per stage.
module ikt_cosdiv import ikt_pkg::*; #(
    parameter int F  = FRAC_BITS_DEF,
    parameter int WN = W_NUM1,
    parameter int WD = W_DEN1,
    parameter int SW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [SW-1:0]        i_side,
    input  logic signed [WN-1:0] i_num,
    input  logic [WD-1:0]        i_den,
    output logic                 o_valid,
    output logic [SW-1:0]        o_side,
    output logic signed [F+1:0]  o_cos,
    output logic                 o_flag
);

    localparam logic signed [F+1:0] ONE = {2'b01, {F{1'b0}}};

    // input stage: magnitude and sign
    logic          r_v0;
    logic [SW-1:0] r_sd0;
    logic [WN-1:0] r_mag;
    logic          r_neg;
    logic [WD-1:0] r_den0;

    // quotient stages, stage 0 holds the integer bit
    logic          r_v  [0:F];
    logic [SW-1:0] r_sd [0:F];
    logic [WD-1:0] r_rem[0:F];
    logic [WD-1:0] r_dd [0:F];
    logic [F:0]    r_q  [0:F];
    logic          r_ng [0:F];
    logic          r_zr [0:F];
    logic          r_ov [0:F];

    logic [WD-1:0] n_rem[0:F];
    logic [F:0]    n_q  [0:F];
    logic          n_zr, n_ov;

    logic [WN-1:0] den_ext;
    logic          ge0;
    logic [WD:0]   sh   [1:F];
    logic          ge   [1:F];

    logic          r_vo;
    logic [SW-1:0] r_sdo;
    logic signed [F+1:0] r_cos;
    logic          r_flo;
    logic signed [F+1:0] qs;

    // restoring division steps
    always_comb begin
        den_ext  = {{(WN-WD){1'b0}}, r_den0};
        ge0      = r_mag >= den_ext;
        n_zr     = r_den0 == '0;
        n_ov     = r_mag > den_ext;
        n_rem[0] = ge0 ? WD'(r_mag - den_ext) : WD'(r_mag);
        n_q[0]   = (F+1)'(ge0);
        for (int k = 1; k <= F; k++) begin
            sh[k]    = {r_rem[k-1], 1'b0};
            ge[k]    = sh[k] >= {1'b0, r_dd[k-1]};
            n_rem[k] = ge[k] ? WD'(sh[k] - {1'b0, r_dd[k-1]}) : WD'(sh[k]);
            n_q[k]   = {r_q[k-1][F-1:0], ge[k]};
        end
        qs = $signed({1'b0, r_q[F]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_vo <= 1'b0;
            for (int k = 0; k <= F; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
            r_v[0] <= r_v0;
            for (int k = 1; k <= F; k++) r_v[k] <= r_v[k-1];
            r_vo <= r_v[F];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd0  <= i_side;
            r_mag  <= i_num[WN-1] ? WN'(-i_num) : WN'(i_num);
            r_neg  <= i_num[WN-1];
            r_den0 <= i_den;

            r_sd[0]  <= r_sd0;
            r_rem[0] <= n_rem[0];
            r_dd[0]  <= r_den0;
            r_q[0]   <= n_q[0];
            r_ng[0]  <= r_neg;
            r_zr[0]  <= n_zr;
            r_ov[0]  <= n_ov;
            for (int k = 1; k <= F; k++) begin
                r_sd[k]  <= r_sd[k-1];
                r_rem[k] <= n_rem[k];
                r_dd[k]  <= r_dd[k-1];
                r_q[k]   <= n_q[k];
                r_ng[k]  <= r_ng[k-1];
                r_zr[k]  <= r_zr[k-1];
                r_ov[k]  <= r_ov[k-1];
            end

            // zero divisor wins over clamping
            r_sdo <= r_sd[F];
            r_flo <= r_zr[F] | r_ov[F];
            if (r_zr[F]) begin
                r_cos <= ONE;
            end else if (r_ov[F]) begin
                r_cos <= r_ng[F] ? -ONE : ONE;
            end else begin
                r_cos <= r_ng[F] ? -qs : qs;
            end
        end
    end

    assign o_valid = r_vo;
    assign o_side  = r_sdo;
    assign o_cos   = r_cos;
    assign o_flag  = r_flo;

endmodule

FILE: rtl/ikt_sqrt.sv
`timescale 1ns / 1ps
// Floor square root of a 2F+1 bit value, one result bit per stage.
module ikt_sqrt import ikt_pkg::*; #(
    parameter int F  = FRAC_BITS_DEF,
    parameter int SW = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [SW-1:0]  i_side,
    input  logic [2*F:0]   i_rad,
    output logic           o_valid,
    output logic [SW-1:0]  o_side,
    output logic [F:0]     o_root
);

    localparam int VW = 2 * F + 1;
    localparam int RW = 2 * F + 2;

    logic          r_v  [0:F];
    logic [SW-1:0] r_sd [0:F];
    logic [VW-1:0] r_rv [0:F];
    logic [RW-1:0] r_rt [0:F];

    logic [VW-1:0] n_rv [0:F];
    logic [RW-1:0] n_rt [0:F];
    logic [VW-1:0] pv   [0:F];
    logic [RW-1:0] pr   [0:F];
    logic [RW-1:0] bj   [0:F];
    logic [RW-1:0] t    [0:F];
    logic          ge   [0:F];

    // digit-by-digit steps, bit weight 4^(F-j) at stage j
    always_comb begin
        for (int j = 0; j <= F; j++) begin
            pv[j] = (j == 0) ? i_rad : r_rv[(j == 0) ? 0 : j-1];
            pr[j] = (j == 0) ? '0    : r_rt[(j == 0) ? 0 : j-1];
            bj[j] = RW'(1) << (2 * (F - j));
            t[j]  = pr[j] + bj[j];
            ge[j] = {1'b0, pv[j]} >= t[j];
            n_rv[j] = ge[j] ? VW'({1'b0, pv[j]} - t[j]) : pv[j];
            n_rt[j] = ge[j] ? (pr[j] >> 1) + bj[j] : pr[j] >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= F; j++) r_v[j] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int j = 1; j <= F; j++) r_v[j] <= r_v[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= i_side;
            for (int j = 1; j <= F; j++) r_sd[j] <= r_sd[j-1];
            for (int j = 0; j <= F; j++) begin
                r_rv[j] <= n_rv[j];
                r_rt[j] <= n_rt[j];
            end
        end
    end

    assign o_valid = r_v[F];
    assign o_side  = r_sd[F];
    assign o_root  = r_rt[F][F:0];

endmodule

FILE: rtl/ikt_cordic.sv
`timescale 1ns / 1ps
// atan2(sin, cos) by vectoring CORDIC on Q30, one micro-rotation per stage.
module ikt_cordic import ikt_pkg::*; #(
    parameter int F  = FRAC_BITS_DEF,
    parameter int SW = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [SW-1:0]       i_side,
    input  logic signed [F+1:0] i_sin,
    input  logic signed [F+1:0] i_cos,
    output logic                o_valid,
    output logic [SW-1:0]       o_side,
    output logic signed [F+2:0] o_angle
);

    localparam int N  = CORDIC_STEPS;
    localparam int CW = CORDIC_W;
    localparam int SH = 30 - F;

    logic                 r_v  [0:N];
    logic [SW-1:0]        r_sd [0:N];
    logic signed [CW-1:0] r_x  [0:N];
    logic signed [CW-1:0] r_y  [0:N];
    logic signed [CW-1:0] r_z  [0:N];
    logic                 r_zf [0:N];

    logic signed [CW-1:0] n_x [0:N];
    logic signed [CW-1:0] n_y [0:N];
    logic signed [CW-1:0] n_z [0:N];
    logic signed [CW-1:0] xi, yi, zr;

    logic                 r_vo;
    logic [SW-1:0]        r_sdo;
    logic signed [F+2:0]  r_ang;

    always_comb begin
        // scale to Q30, fold the left half plane by a quarter turn
        xi = CW'(i_cos) <<< SH;
        yi = CW'(i_sin) <<< SH;
        n_x[0] = xi;
        n_y[0] = yi;
        n_z[0] = '0;
        if (xi[CW-1]) begin
            if (!yi[CW-1]) begin
                n_x[0] = yi;
                n_y[0] = -xi;
                n_z[0] = HALF_PI_Q30;
            end else begin
                n_x[0] = -yi;
                n_y[0] = xi;
                n_z[0] = -HALF_PI_Q30;
            end
        end
        // micro-rotations toward y = 0
        for (int i = 0; i < N; i++) begin
            if (!r_y[i][CW-1] && r_y[i] != '0) begin
                n_x[i+1] = r_x[i] + (r_y[i] >>> i);
                n_y[i+1] = r_y[i] - (r_x[i] >>> i);
                n_z[i+1] = r_z[i] + atan_q30(i);
            end else begin
                n_x[i+1] = r_x[i] - (r_y[i] >>> i);
                n_y[i+1] = r_y[i] + (r_x[i] >>> i);
                n_z[i+1] = r_z[i] - atan_q30(i);
            end
        end
        // round half up to F fraction bits
        zr = (r_z[N] + (CW'(1) <<< (SH - 1))) >>> SH;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= N; i++) r_v[i] <= 1'b0;
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int i = 1; i <= N; i++) r_v[i] <= r_v[i-1];
            r_vo <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= i_side;
            r_zf[0] <= (i_sin == '0) && (i_cos == '0);
            for (int i = 1; i <= N; i++) begin
                r_sd[i] <= r_sd[i-1];
                r_zf[i] <= r_zf[i-1];
            end
            for (int i = 0; i <= N; i++) begin
                r_x[i] <= n_x[i];
                r_y[i] <= n_y[i];
                r_z[i] <= n_z[i];
            end
            r_sdo <= r_sd[N];
            r_ang <= r_zf[N] ? '0 : zr[F+2:0];
        end
    end

    assign o_valid = r_vo;
    assign o_side  = r_sdo;
    assign o_angle = r_ang;

endmodule

FILE: rtl/inverse_kinematics_three_link.sv
// Throughput: one target per cycle; the whole pipeline advances on one enable and
// holds while the output word waits.
// The cost is two chains of divider, square root and 28-step CORDIC stages.
// Reset: synchronous, active low; clears all valid bits and loads register defaults.
`timescale 1ns / 1ps
module inverse_kinematics_three_link import ikt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ikt_cfg_if.sink     i_cfg,
    ikt_in_if.sink      i_in,
    ikt_out_if.source   o_out
);

    localparam int F  = FRAC_BITS;
    localparam int WP = F + 20;

    typedef struct packed {
        logic signed [W_DX-1:0] dx;
        logic signed [W_DZ-1:0] dz;
    } t_s1;

    typedef struct packed {
        logic signed [F+1:0]    c2;
        logic signed [W_DX-1:0] dx;
        logic signed [W_DZ-1:0] dz;
        logic                   fl;
    } t_s2;

    typedef struct packed {
        logic signed [F+1:0]    c2;
        logic [F:0]             s2;
        logic signed [W_DX-1:0] dx;
        logic signed [W_DZ-1:0] dz;
        logic                   fl;
    } t_s3;

    typedef struct packed {
        logic signed [F+2:0] q2;
        logic                fl;
    } t_s4;

    typedef struct packed {
        logic signed [F+1:0] c3;
        logic signed [F+2:0] q2;
        logic                fl;
    } t_s5;

    // configuration registers
    logic [W_LEN-1:0]          r_len0, r_len1, r_len2;
    logic signed [W_HOFF-1:0]  r_hx, r_hz;
    logic signed [W_PITCH-1:0] r_pitch;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len0  <= RST_FOOT_TO_ANKLE;
            r_len1  <= RST_ANKLE_TO_KNEE;
            r_len2  <= RST_KNEE_TO_HIP;
            r_hx    <= RST_HIP_OFFSET_X;
            r_hz    <= RST_HIP_OFFSET_Z;
            r_pitch <= RST_PITCH_OFFSET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_FOOT_TO_ANKLE: r_len0  <= i_cfg.data[W_LEN-1:0];
                CFG_ANKLE_TO_KNEE: r_len1  <= i_cfg.data[W_LEN-1:0];
                CFG_KNEE_TO_HIP:   r_len2  <= i_cfg.data[W_LEN-1:0];
                CFG_HIP_OFFSET_X:  r_hx    <= $signed(i_cfg.data[W_HOFF-1:0]);
                CFG_HIP_OFFSET_Z:  r_hz    <= $signed(i_cfg.data[W_HOFF-1:0]);
                CFG_PITCH_OFFSET:  r_pitch <= $signed(i_cfg.data[W_PITCH-1:0]);
                default: ;
            endcase
        end
    end

    // global pipeline enable
    logic en;
    logic r_out_v;
    assign en         = !r_out_v || o_out.ready;
    assign i_in.ready = en;

    logic signed [W_LEN:0] l0s, l1s, l2s;
    assign l0s = $signed({1'b0, r_len0});
    assign l1s = $signed({1'b0, r_len1});
    assign l2s = $signed({1'b0, r_len2});

    // stage registers
    logic                     r1_v, r2_v, r3_v, r4_v, r5_v;
    logic                     r6_v, r7_v, r8_v, r9_v, r10_v, r11_v;
    logic signed [W_DX-1:0]   r1_dx, r2_dx;
    logic signed [W_DZ-1:0]   r1_dz, r2_dz;
    logic signed [W_NUM1-1:0] r2_dxx, r2_dzz, r2_l11, r2_l22;
    logic [W_DEN1-1:0]        r2_l12;
    logic signed [W_NUM1-1:0] r3_num;
    logic [W_DEN1-1:0]        r3_den;
    t_s1                      r3_s;
    t_s2                      r4_s, r5_s;
    logic [2*F:0]             r4_csq, r5_rad;
    logic signed [WP-1:0]     r6_pa, r6_pb;
    logic signed [W_AB-1:0]   r7_a, r7_b;
    logic signed [F+2:0]      r6_q2, r7_q2;
    t_s3                      r6_s, r7_s;
    logic signed [W_NUM3-1:0] r8_adz, r8_bdx, r9_num;
    logic [W_DEN3-1:0]        r8_aa, r8_bb, r9_den;
    t_s4                      r8_s, r9_s;
    t_s5                      r10_s, r11_s;
    logic [2*F:0]             r10_csq, r11_rad;

    // unit outputs
    logic                d1_v, d3_v, sq1_v, sq3_v, co1_v, co3_v;
    t_s1                 d1_side;
    t_s4                 d3_side, co3_side;
    logic signed [F+1:0] d1_cos, d3_cos;
    logic                d1_fl, d3_fl;
    t_s2                 sq1_side;
    t_s5                 sq3_side;
    logic [F:0]          sq1_root, sq3_root;
    t_s3                 co1_in, co1_side;
    t_s4                 co3_in;
    logic signed [F+2:0] co1_ang, co3_ang;
    logic signed [F+1:0] s3_neg;

    logic [2*F:0]        one_sq;
    assign one_sq = {1'b1, {(2*F){1'b0}}};

    logic signed [2*F+3:0] c2_wide, c3_wide;
    assign c2_wide = (2*F+4)'(d1_cos);
    assign c3_wide = (2*F+4)'(d3_cos);

    logic signed [WP-1:0] sum_a, sum_b, half;
    assign half  = WP'(1) <<< (F - 1);
    assign sum_a = -r6_pa - (WP'(l2s) <<< F) + half;
    assign sum_b = -r6_pb + half;

    logic signed [31:0] hip_sum;
    assign hip_sum = 32'(r_pitch) - 32'(co3_side.q2) - 32'(co3_ang);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0; r4_v <= 1'b0;
            r5_v  <= 1'b0; r6_v <= 1'b0; r7_v <= 1'b0; r8_v <= 1'b0;
            r9_v  <= 1'b0; r10_v <= 1'b0; r11_v <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r1_v  <= i_in.valid;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r4_v  <= d1_v;
            r5_v  <= r4_v;
            r6_v  <= co1_v;
            r7_v  <= r6_v;
            r8_v  <= r7_v;
            r9_v  <= r8_v;
            r10_v <= d3_v;
            r11_v <= r10_v;
            r_out_v <= co3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // offsets from the hip
            r1_dx <= W_DX'(i_in.x_target) - W_DX'(r_hx);
            r1_dz <= W_DZ'(i_in.z_target) - W_DZ'(r_hz) + W_DZ'(l0s);

            // squares and link products
            r2_dx  <= r1_dx;
            r2_dz  <= r1_dz;
            r2_dxx <= W_NUM1'(r1_dx) * W_NUM1'(r1_dx);
            r2_dzz <= W_NUM1'(r1_dz) * W_NUM1'(r1_dz);
            r2_l11 <= W_NUM1'(l1s) * W_NUM1'(l1s);
            r2_l22 <= W_NUM1'(l2s) * W_NUM1'(l2s);
            r2_l12 <= W_DEN1'(r_len1) * W_DEN1'(r_len2);

            // knee cosine terms
            r3_num  <= r2_dxx + r2_dzz - r2_l11 - r2_l22;
            r3_den  <= r2_l12 << 1;
            r3_s.dx <= r2_dx;
            r3_s.dz <= r2_dz;

            // knee sine radicand
            r4_s.c2 <= d1_cos;
            r4_s.dx <= d1_side.dx;
            r4_s.dz <= d1_side.dz;
            r4_s.fl <= d1_fl;
            r4_csq  <= (2*F+1)'(c2_wide * c2_wide);
            r5_s    <= r4_s;
            r5_rad  <= one_sq - r4_csq;

            // A and B products, knee angle rides along
            r6_s  <= co1_side;
            r6_q2 <= co1_ang;
            r6_pa <= WP'(l1s) * WP'(co1_side.c2);
            r6_pb <= WP'(l1s) * WP'($signed({1'b0, co1_side.s2}));
            r7_s  <= r6_s;
            r7_q2 <= r6_q2;
            r7_a  <= W_AB'(sum_a >>> F);
            r7_b  <= W_AB'(sum_b >>> F);

            // ankle cosine terms
            r8_adz  <= W_NUM3'(r7_a) * W_NUM3'(r7_s.dz);
            r8_bdx  <= W_NUM3'(r7_b) * W_NUM3'(r7_s.dx);
            r8_aa   <= W_DEN3'(W_NUM3'(r7_a) * W_NUM3'(r7_a));
            r8_bb   <= W_DEN3'(W_NUM3'(r7_b) * W_NUM3'(r7_b));
            r8_s.q2 <= r7_q2;
            r8_s.fl <= r7_s.fl;
            r9_num  <= r8_adz + r8_bdx;
            r9_den  <= r8_aa + r8_bb;
            r9_s    <= r8_s;

            // ankle sine radicand
            r10_s.c3 <= d3_cos;
            r10_s.q2 <= d3_side.q2;
            r10_s.fl <= d3_side.fl | d3_fl;
            r10_csq  <= (2*F+1)'(c3_wide * c3_wide);
            r11_s    <= r10_s;
            r11_rad  <= one_sq - r10_csq;

            // output word
            o_out.hip_angle   <= hip_sum[W_HIP-1:0];
            o_out.knee_angle  <= W_JNT'(co3_side.q2);
            o_out.ankle_angle <= W_JNT'(co3_ang);
            o_out.unreachable <= co3_side.fl;
        end
    end

    assign o_out.valid = r_out_v;

    // knee: cosine, sine, angle
    ikt_cosdiv #(.F(F), .WN(W_NUM1), .WD(W_DEN1), .SW($bits(t_s1))) u_div_knee (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r3_v), .i_side(r3_s), .i_num(r3_num), .i_den(r3_den),
        .o_valid(d1_v), .o_side(d1_side), .o_cos(d1_cos), .o_flag(d1_fl)
    );

    ikt_sqrt #(.F(F), .SW($bits(t_s2))) u_sqrt_knee (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r5_v), .i_side(r5_s), .i_rad(r5_rad),
        .o_valid(sq1_v), .o_side(sq1_side), .o_root(sq1_root)
    );

    always_comb begin
        co1_in.c2 = sq1_side.c2;
        co1_in.s2 = sq1_root;
        co1_in.dx = sq1_side.dx;
        co1_in.dz = sq1_side.dz;
        co1_in.fl = sq1_side.fl;
    end

    ikt_cordic #(.F(F), .SW($bits(t_s3))) u_atan_knee (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(sq1_v), .i_side(co1_in),
        .i_sin($signed({1'b0, sq1_root})), .i_cos(sq1_side.c2),
        .o_valid(co1_v), .o_side(co1_side), .o_angle(co1_ang)
    );

    // ankle: cosine, negative sine, angle
    ikt_cosdiv #(.F(F), .WN(W_NUM3), .WD(W_DEN3), .SW($bits(t_s4))) u_div_ankle (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r9_v), .i_side(r9_s), .i_num(r9_num), .i_den(r9_den),
        .o_valid(d3_v), .o_side(d3_side), .o_cos(d3_cos), .o_flag(d3_fl)
    );

    ikt_sqrt #(.F(F), .SW($bits(t_s5))) u_sqrt_ankle (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r11_v), .i_side(r11_s), .i_rad(r11_rad),
        .o_valid(sq3_v), .o_side(sq3_side), .o_root(sq3_root)
    );

    assign s3_neg    = -$signed({1'b0, sq3_root});
    assign co3_in.q2 = sq3_side.q2;
    assign co3_in.fl = sq3_side.fl;

    ikt_cordic #(.F(F), .SW($bits(t_s4))) u_atan_ankle (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(sq3_v), .i_side(co3_in),
        .i_sin(s3_neg), .i_cos(sq3_side.c3),
        .o_valid(co3_v), .o_side(co3_side), .o_angle(co3_ang)
    );

endmodule
